// ===== sv/qbse_pkg.sv =====
// ----------------------------------------------------------------------------
// qbse_pkg
// Shared types and constants of the quadratic B-spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package qbse_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 7;
  localparam int INV_KNOT_W    = 24;
  localparam int INDEX_W       = 6;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = DATA_W + INV_KNOT_W + 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [COUNT_W-1:0]    COUNT_RESET    = 7'd64;
  localparam logic [INV_KNOT_W-1:0] INV_KNOT_RESET = 24'd65536;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic REG_SPLINE_COUNT = 1'b0;
  localparam logic REG_INV_KNOT     = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_EVAL,
    KIND_ERROR
  } qbse_kind_t;

  typedef struct packed {
    qbse_kind_t kind;
    logic       last;
  } qbse_ctl_t;

endpackage

`default_nettype wire

// ===== sv/qbse_if.sv =====
// ----------------------------------------------------------------------------
// qbse_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbse_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         coeff_index;
  logic signed [31:0] coeff_value;
  logic signed [31:0] sample_time;

  modport source (output valid, operation, coeff_index, coeff_value, sample_time,
                  input ready);
  modport sink   (input valid, operation, coeff_index, coeff_value, sample_time,
                  output ready);
endinterface

interface qbse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] spline_value;
  logic               range_error;

  modport source (output valid, spline_value, range_error, input ready);
  modport sink   (input valid, spline_value, range_error, output ready);
endinterface

`default_nettype wire

// ===== sv/qbse_ram.sv =====
// ----------------------------------------------------------------------------
// qbse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qbse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/qbse_queue.sv =====
// ----------------------------------------------------------------------------
// qbse_queue
// Short FIFO between the front and back parts of the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module qbse_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qbse_front.sv =====
// ----------------------------------------------------------------------------
// qbse_front
// Accepts items, scales the sample time and classifies each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module qbse_front #(
  parameter int MAX_SPLINES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qbse_in_if.sink                           in_if,
  input  logic [qbse_pkg::COUNT_W-1:0]      spline_count,
  input  logic [qbse_pkg::INV_KNOT_W-1:0]   inv_knot_spacing,
  input  logic                              busy,
  output logic                              push_valid,
  input  logic                              push_ready,
  output qbse_pkg::qbse_ctl_t               push_ctl,
  output logic [$clog2(MAX_SPLINES)-1:0]    push_addr,
  output logic [qbse_pkg::DATA_W-1:0]       push_data
);

  import qbse_pkg::*;

  localparam int AW  = $clog2(MAX_SPLINES);
  localparam int NW0 = $clog2(MAX_SPLINES + 1);
  localparam int NW  = (NW0 > COUNT_W) ? NW0 : COUNT_W;

  logic                     s1_valid_r;
  logic                     s1_op_r;
  logic [INDEX_W-1:0]       s1_idx_r;
  logic [DATA_W-1:0]        s1_value_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     advance;
  logic                     take;

  logic [NW-1:0]            count_ext;
  logic [NW-1:0]            n_clamped;
  logic [NW-1:0]            last_interval;
  logic [INV_KNOT_W-1:0]    interval;
  logic                     negative;
  logic                     keep;

  assign advance     = !s1_valid_r || push_ready;
  assign in_if.ready = advance && !busy;
  assign take        = in_if.valid && in_if.ready;
  assign prod_nxt    = in_if.sample_time * $signed({1'b0, inv_knot_spacing});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r    <= in_if.operation;
      s1_idx_r   <= in_if.coeff_index;
      s1_value_r <= in_if.coeff_value;
      s1_prod_r  <= prod_nxt;
    end
  end

  always_comb begin
    count_ext = NW'(spline_count);
    if (count_ext < NW'(3)) begin
      n_clamped = NW'(3);
    end else if (count_ext > NW'(MAX_SPLINES)) begin
      n_clamped = NW'(MAX_SPLINES);
    end else begin
      n_clamped = count_ext;
    end
    last_interval = n_clamped - NW'(2);
    negative      = s1_prod_r[PROD_W-1];
    interval      = s1_prod_r[PROD_W-2:2*FRAC_W];

    push_ctl.last = (interval == INV_KNOT_W'(last_interval));
    if (s1_op_r == OP_LOAD) begin
      keep          = (int'(s1_idx_r) < MAX_SPLINES);
      push_ctl.kind = KIND_LOAD;
      push_addr     = AW'(s1_idx_r);
      push_data     = s1_value_r;
    end else begin
      keep          = 1'b1;
      push_addr     = AW'(interval);
      push_data     = DATA_W'(s1_prod_r[2*FRAC_W-1:FRAC_W]);
      if (negative || (interval > INV_KNOT_W'(last_interval))) begin
        push_ctl.kind = KIND_ERROR;
      end else begin
        push_ctl.kind = KIND_EVAL;
      end
    end
    push_valid = s1_valid_r && keep;
  end

  a_no_accept_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(in_if.valid && in_if.ready))
    else $error("Item accepted while the coefficient store is being cleared.");

endmodule

`default_nettype wire

// ===== sv/qbse_back.sv =====
// ----------------------------------------------------------------------------
// qbse_back
// Coefficient store, weight computation, blending and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qbse_back #(
  parameter int MAX_SPLINES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  qbse_pkg::qbse_ctl_t            pop_ctl,
  input  logic [$clog2(MAX_SPLINES)-1:0] pop_addr,
  input  logic [qbse_pkg::DATA_W-1:0]    pop_data,
  output logic                           busy,
  qbse_out_if.source                     out_if
);

  import qbse_pkg::*;

  localparam int AW = $clog2(MAX_SPLINES);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          advance;
  logic          take;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     raddr [3];
  logic [DATA_W-1:0] rdata [3];

  logic                b1_valid_r, b1_err_r, b1_last_r;
  logic [FRAC_W-1:0]   b1_f_r;
  logic [FRAC_W:0]     one_minus_f;
  logic [33:0]         w0_full;
  logic signed [FRAC_W:0] f_centered;
  logic signed [33:0]  d_sq_full;
  logic [31:0]         f_sq;
  logic [32:0]         w_nxt [3];

  logic                b2_valid_r, b2_err_r;
  logic [32:0]         b2_w_r [3];
  logic signed [DATA_W-1:0] b2_c_r [3];

  logic                b3_valid_r, b3_err_r;
  logic signed [48:0]  b3_hi_r [3];
  logic signed [49:0]  b3_lo_r [3];
  logic signed [48:0]  hi_nxt [3];
  logic signed [49:0]  lo_nxt [3];

  logic                b4_valid_r, b4_err_r;
  logic signed [50:0]  b4_hi_r;
  logic signed [51:0]  b4_lo_r;

  logic signed [68:0]  total;
  logic signed [35:0]  rounded;
  logic signed [31:0]  saturated;

  logic                out_valid_r;
  logic signed [31:0]  out_value_r;
  logic                out_error_r;

  assign advance   = !out_valid_r || out_if.ready;
  assign pop_ready = advance && !busy_r;
  assign take      = pop_valid && pop_ready;
  assign busy      = busy_r;

  always_comb begin
    busy_nxt    = busy_r;
    clr_cnt_nxt = clr_cnt_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MAX_SPLINES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign ram_we    = busy_r || (take && (pop_ctl.kind == KIND_LOAD));
  assign ram_waddr = busy_r ? clr_cnt_r : pop_addr;
  assign ram_wdata = busy_r ? '0 : pop_data;
  assign raddr[0]  = pop_addr;
  assign raddr[1]  = pop_addr + AW'(1);
  assign raddr[2]  = pop_addr + AW'(2);

  for (genvar i = 0; i < 3; i++) begin : g_bank
    qbse_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_SPLINES)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (advance),
      .raddr(raddr[i]),
      .rdata(rdata[i])
    );
  end

  always_comb begin
    one_minus_f = 17'h10000 - {1'b0, b1_f_r};
    w0_full     = one_minus_f * one_minus_f;
    f_centered  = $signed({1'b0, b1_f_r}) - 17'sd32768;
    d_sq_full   = f_centered * f_centered;
    f_sq        = b1_f_r * b1_f_r;
    w_nxt[0]    = w0_full[32:0];
    w_nxt[1]    = 33'h1_8000_0000 - {1'b0, d_sq_full[30:0], 1'b0};
    w_nxt[2]    = b1_last_r ? '0 : {1'b0, f_sq};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_nxt[i] = b2_c_r[i] * $signed({1'b0, b2_w_r[i][32:17]});
      lo_nxt[i] = b2_c_r[i] * $signed({1'b0, b2_w_r[i][16:0]});
    end
  end

  always_comb begin
    total   = (69'(b4_hi_r) <<< 17) + 69'(b4_lo_r);
    rounded = total[68:33];
    if (rounded > 36'sd2147483647) begin
      saturated = 32'sh7FFF_FFFF;
    end else if (rounded < -36'sd2147483648) begin
      saturated = 32'sh8000_0000;
    end else begin
      saturated = rounded[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      b4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= take && (pop_ctl.kind != KIND_LOAD);
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      b4_valid_r  <= b3_valid_r;
      out_valid_r <= b4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1_err_r  <= (pop_ctl.kind == KIND_ERROR);
      b1_last_r <= pop_ctl.last;
      b1_f_r    <= pop_data[FRAC_W-1:0];
      b2_err_r  <= b1_err_r;
      b3_err_r  <= b2_err_r;
      b4_err_r  <= b3_err_r;
      for (int i = 0; i < 3; i++) begin
        b2_w_r[i]  <= w_nxt[i];
        b2_c_r[i]  <= $signed(rdata[i]);
        b3_hi_r[i] <= hi_nxt[i];
        b3_lo_r[i] <= lo_nxt[i];
      end
      b4_hi_r     <= 51'(b3_hi_r[0]) + 51'(b3_hi_r[1]) + 51'(b3_hi_r[2]);
      b4_lo_r     <= 52'(b3_lo_r[0]) + 52'(b3_lo_r[1]) + 52'(b3_lo_r[2])
                     + 52'sh1_0000_0000;
      out_error_r <= b4_err_r;
      out_value_r <= b4_err_r ? '0 : saturated;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.spline_value = out_value_r;
  assign out_if.range_error  = out_error_r;

  a_no_pop_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop_ready)
    else $error("Queue entry taken while the coefficient store is being cleared.");

  a_error_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_value_r == '0))
    else $error("Range error result carries a nonzero value.");

  a_clear_covers_store : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> ($past(clr_cnt_r) == AW'(MAX_SPLINES - 1)))
    else $error("Clearing pass ended before the last coefficient slot.");

endmodule

`default_nettype wire

// ===== sv/quadratic_bspline_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// quadratic_bspline_evaluator_top
// Uniform quadratic B-spline evaluator with a loadable coefficient store.
//
// Items arrive on in_if as valid/ready transactions. A load transaction
// writes one coefficient and produces no result. An evaluate transaction
// produces one result on out_if, the saturated Q16.16 spline value or a
// range error with a zero value. The APB port sets the spline count and the
// reciprocal knot spacing and should only be written while the block is idle.
// Throughput is one transaction per cycle while not clearing and while the
// receiver does not stall. A result passes in turn through the scaling
// multiply, the queue, the registered coefficient read, the weight squares,
// the coefficient products and the final sum with rounding. After reset the
// block clears all MAX_SPLINES coefficient slots, one per cycle, and holds
// in_if.ready low while it does so. When the receiver stalls, the back
// pipeline holds and the queue and front stage keep accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_bspline_evaluator_top #(
  parameter int MAX_SPLINES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  qbse_in_if.sink     in_if,
  qbse_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import qbse_pkg::*;

  localparam int AW  = $clog2(MAX_SPLINES);
  localparam int CTW = $bits(qbse_ctl_t);
  localparam int QW  = CTW + AW + DATA_W;

  logic [COUNT_W-1:0]    spline_count_r;
  logic [INV_KNOT_W-1:0] inv_knot_spacing_r;
  logic                  cfg_write;

  logic              busy;
  logic              push_valid, push_ready;
  qbse_ctl_t         push_ctl;
  logic [AW-1:0]     push_addr;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [QW-1:0]     pop_word;
  qbse_ctl_t         pop_ctl;
  logic [AW-1:0]     pop_addr;
  logic [DATA_W-1:0] pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spline_count_r     <= COUNT_RESET;
      inv_knot_spacing_r <= INV_KNOT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SPLINE_COUNT: spline_count_r     <= pwdata[COUNT_W-1:0];
        REG_INV_KNOT:     inv_knot_spacing_r <= pwdata[INV_KNOT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPLINE_COUNT: prdata = 32'(spline_count_r);
      REG_INV_KNOT:     prdata = 32'(inv_knot_spacing_r);
      default:          prdata = '0;
    endcase
  end

  qbse_front #(
    .MAX_SPLINES(MAX_SPLINES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (in_if),
    .spline_count    (spline_count_r),
    .inv_knot_spacing(inv_knot_spacing_r),
    .busy            (busy),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_ctl        (push_ctl),
    .push_addr       (push_addr),
    .push_data       (push_data)
  );

  qbse_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_ctl, push_addr, push_data}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_word)
  );

  assign pop_ctl  = pop_word[QW-1:AW+DATA_W];
  assign pop_addr = pop_word[AW+DATA_W-1:DATA_W];
  assign pop_data = pop_word[DATA_W-1:0];

  qbse_back #(
    .MAX_SPLINES(MAX_SPLINES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_ctl  (pop_ctl),
    .pop_addr (pop_addr),
    .pop_data (pop_data),
    .busy     (busy),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire
